// ===== design/rchsu_pkg.sv =====
package rchsu_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned ChanWidth   = 11;
   localparam int unsigned NumAnalog   = 4;
   localparam int unsigned NumSwitches = 7;
   localparam int unsigned SlotWidth   = 3;

   // packet type codes (header bits 1..0)
   localparam logic [1:0] PKT_TYPE_RC = 2'd0;

   // slot that holds the 16-position switch
   localparam logic [SlotWidth-1:0] SLOT_POS16 = 3'd6;

   localparam logic [ChanWidth-1:0] VAL_LOW  = 11'd191;
   localparam logic [ChanWidth-1:0] VAL_MID  = 11'd992;
   localparam logic [ChanWidth-1:0] VAL_HIGH = 11'd1792;

   typedef logic [ChanWidth-1:0] chan_type;

   typedef struct packed {
      logic [ByteWidth-1:0] header_byte;
      logic [ByteWidth-1:0] analog_high_0;
      logic [ByteWidth-1:0] analog_high_1;
      logic [ByteWidth-1:0] analog_high_2;
      logic [ByteWidth-1:0] analog_high_3;
      logic [ByteWidth-1:0] analog_low_bits;
      logic [ByteWidth-1:0] switch_byte;
   } req_item_type;

   // one stored-switch write
   typedef struct packed {
      logic [SlotWidth-1:0] slot;
      chan_type             value;
   } sw_update_type;

   // 3-bit position: 0 -> low, 5 -> high, 6/7 -> mid, else pos*240+391
   function automatic chan_type pos3_map(input logic [2:0] pos);
      chan_type result;
      unique case (pos)
         3'd0:    result = VAL_LOW;
         3'd1:    result = 11'd631;
         3'd2:    result = 11'd871;
         3'd3:    result = 11'd1111;
         3'd4:    result = 11'd1351;
         3'd5:    result = VAL_HIGH;
         default: result = VAL_MID;
      endcase
      return result;
   endfunction

   // 16-position: v*1601/15 + 191, quotient truncated
   function automatic chan_type pos16_map(input logic [3:0] v);
      chan_type result;
      unique case (v)
         4'd0:    result = 11'd191;
         4'd1:    result = 11'd297;
         4'd2:    result = 11'd404;
         4'd3:    result = 11'd511;
         4'd4:    result = 11'd617;
         4'd5:    result = 11'd724;
         4'd6:    result = 11'd831;
         4'd7:    result = 11'd938;
         4'd8:    result = 11'd1044;
         4'd9:    result = 11'd1151;
         4'd10:   result = 11'd1258;
         4'd11:   result = 11'd1365;
         4'd12:   result = 11'd1471;
         4'd13:   result = 11'd1578;
         4'd14:   result = 11'd1685;
         default: result = 11'd1792;
      endcase
      return result;
   endfunction

endpackage

// ===== design/rchsu_if.sv =====
interface rchsu_req_if;
   logic                                valid;
   logic                                ready;
   logic [rchsu_pkg::ByteWidth-1:0]     header_byte;
   logic [rchsu_pkg::ByteWidth-1:0]     analog_high_0;
   logic [rchsu_pkg::ByteWidth-1:0]     analog_high_1;
   logic [rchsu_pkg::ByteWidth-1:0]     analog_high_2;
   logic [rchsu_pkg::ByteWidth-1:0]     analog_high_3;
   logic [rchsu_pkg::ByteWidth-1:0]     analog_low_bits;
   logic [rchsu_pkg::ByteWidth-1:0]     switch_byte;

   modport source (
      output valid, header_byte, analog_high_0, analog_high_1, analog_high_2,
             analog_high_3, analog_low_bits, switch_byte,
      input  ready
   );
   modport sink (
      input  valid, header_byte, analog_high_0, analog_high_1, analog_high_2,
             analog_high_3, analog_low_bits, switch_byte,
      output ready
   );
endinterface

interface rchsu_rsp_if;
   logic                  valid;
   logic                  ready;
   rchsu_pkg::chan_type   chan_0;
   rchsu_pkg::chan_type   chan_1;
   rchsu_pkg::chan_type   chan_2;
   rchsu_pkg::chan_type   chan_3;
   rchsu_pkg::chan_type   chan_4;
   rchsu_pkg::chan_type   chan_5;
   rchsu_pkg::chan_type   chan_6;
   rchsu_pkg::chan_type   chan_7;
   rchsu_pkg::chan_type   chan_8;
   rchsu_pkg::chan_type   chan_9;
   rchsu_pkg::chan_type   chan_10;
   rchsu_pkg::chan_type   chan_11;

   modport source (
      output valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6,
             chan_7, chan_8, chan_9, chan_10, chan_11,
      input  ready
   );
   modport sink (
      input  valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6,
             chan_7, chan_8, chan_9, chan_10, chan_11,
      output ready
   );
endinterface

// ===== design/rchsu_decode.sv =====
module rchsu_decode (
   input  rchsu_pkg::req_item_type  item,
   output rchsu_pkg::chan_type      analog [rchsu_pkg::NumAnalog],
   output rchsu_pkg::chan_type      fast_sw,
   output rchsu_pkg::sw_update_type sw_update
);

   logic [2:0] rr_index;

   // high byte in bits 10..3, shared low pair in bits 2..1, bit 0 zero
   assign analog[0] = {item.analog_high_0, item.analog_low_bits[7:6], 1'b0};
   assign analog[1] = {item.analog_high_1, item.analog_low_bits[5:4], 1'b0};
   assign analog[2] = {item.analog_high_2, item.analog_low_bits[3:2], 1'b0};
   assign analog[3] = {item.analog_high_3, item.analog_low_bits[1:0], 1'b0};

   assign fast_sw  = item.switch_byte[6] ? rchsu_pkg::VAL_HIGH : rchsu_pkg::VAL_LOW;
   assign rr_index = item.switch_byte[5:3];

   always_comb begin
      if (rr_index < rchsu_pkg::SLOT_POS16) begin
         sw_update.slot  = rr_index;
         sw_update.value = rchsu_pkg::pos3_map(item.switch_byte[2:0]);
      end else begin
         // indexes 6 and 7 share the 16-position slot
         sw_update.slot  = rchsu_pkg::SLOT_POS16;
         sw_update.value = rchsu_pkg::pos16_map(item.switch_byte[3:0]);
      end
   end

endmodule

// ===== design/rc_hybrid_switch_unpacker.sv =====
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    header_byte, analog_high_0..3, analog_low_bits,
//                              switch_byte (8 bits each)
// rsp_ch   out  valid/ready    chan_0..chan_11 (11 bits each)
//
// Two register stages: input register, then result register. A req transaction
// is captured in the input register and its result moves to the result register,
// which drives rsp valid. One transaction per cycle sustained while rsp is not
// stalled. Non-RC packets are dropped in the first stage without touching state
// or the result register. Synchronous active-high reset empties both stages and
// zeroes the seven stored switch channels. A stalled rsp holds; req keeps flowing
// while the input stage can drain (non-RC packets always drain).
module rc_hybrid_switch_unpacker (
   input  logic               clock,
   input  logic               reset,
   rchsu_req_if.sink          req_ch,
   rchsu_rsp_if.source        rsp_ch
);

   // ---- input stage ----
   logic                         in_valid_ff;
   logic                         in_valid_in;
   rchsu_pkg::req_item_type      in_data_ff;
   rchsu_pkg::req_item_type      req_item;

   // ---- result stage ----
   logic                         out_valid_ff;
   logic                         out_valid_in;
   rchsu_pkg::chan_type          analog_ff [rchsu_pkg::NumAnalog];
   rchsu_pkg::chan_type          fast_ff;

   // ---- stored switch channels ----
   rchsu_pkg::chan_type          switch_ff [rchsu_pkg::NumSwitches];
   rchsu_pkg::chan_type          switch_in [rchsu_pkg::NumSwitches];

   // ---- decode outputs ----
   rchsu_pkg::chan_type          analog_dec [rchsu_pkg::NumAnalog];
   rchsu_pkg::chan_type          fast_dec;
   rchsu_pkg::sw_update_type     sw_update;

   logic                         req_fire;
   logic                         s1_is_rc;
   logic                         out_free;
   logic                         s1_adv;
   logic                         s1_emit;

   assign req_item.header_byte     = req_ch.header_byte;
   assign req_item.analog_high_0   = req_ch.analog_high_0;
   assign req_item.analog_high_1   = req_ch.analog_high_1;
   assign req_item.analog_high_2   = req_ch.analog_high_2;
   assign req_item.analog_high_3   = req_ch.analog_high_3;
   assign req_item.analog_low_bits = req_ch.analog_low_bits;
   assign req_item.switch_byte     = req_ch.switch_byte;

   // Flow control: result slot is free when empty or being taken this cycle.
   assign s1_is_rc = (in_data_ff.header_byte[1:0] == rchsu_pkg::PKT_TYPE_RC);
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign s1_adv   = in_valid_ff && (!s1_is_rc || out_free);
   assign s1_emit  = in_valid_ff && s1_is_rc && out_free;

   assign req_ch.ready = !in_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !s1_adv);
   assign out_valid_in = s1_emit || (out_valid_ff && !rsp_ch.ready);

   rchsu_decode u_decode (
      .item      (in_data_ff),
      .analog    (analog_dec),
      .fast_sw   (fast_dec),
      .sw_update (sw_update)
   );

   // Next stored-switch state: one slot rewritten per RC transaction.
   always_comb begin
      for (int i = 0; i < rchsu_pkg::NumSwitches; i++) begin
         if (s1_emit && (sw_update.slot == rchsu_pkg::SlotWidth'(i))) begin
            switch_in[i] = sw_update.value;
         end else begin
            switch_in[i] = switch_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < rchsu_pkg::NumSwitches; i++) begin
            switch_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         switch_ff    <= switch_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_item;
      end
      if (s1_emit) begin
         analog_ff <= analog_dec;
         fast_ff   <= fast_dec;
      end
   end

   // Stored channels shown from switch_ff: they change only on s1_emit, which
   // also loads the result register, so they track the held result.
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.chan_0  = analog_ff[0];
   assign rsp_ch.chan_1  = analog_ff[1];
   assign rsp_ch.chan_2  = analog_ff[2];
   assign rsp_ch.chan_3  = analog_ff[3];
   assign rsp_ch.chan_4  = fast_ff;
   assign rsp_ch.chan_5  = switch_ff[0];
   assign rsp_ch.chan_6  = switch_ff[1];
   assign rsp_ch.chan_7  = switch_ff[2];
   assign rsp_ch.chan_8  = switch_ff[3];
   assign rsp_ch.chan_9  = switch_ff[4];
   assign rsp_ch.chan_10 = switch_ff[5];
   assign rsp_ch.chan_11 = switch_ff[6];

endmodule

// ===== design/rchsu_checker.sv =====
module rchsu_checker (
   input logic          clock,
   input logic          reset,
   rchsu_req_if.sink    req_ch,
   rchsu_rsp_if.source  rsp_ch
);

   // stalled transaction stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("rsp valid dropped while stalled");

   // stalled transaction holds its payload (chan_0, chan_4 and chan_11 checked)
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.chan_0) && $stable(rsp_ch.chan_4) && $stable(rsp_ch.chan_11))
      else $error("rsp payload changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("rsp valid right after reset");

   // fast switch only takes its two levels
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.chan_4 == rchsu_pkg::VAL_LOW) ||
                       (rsp_ch.chan_4 == rchsu_pkg::VAL_HIGH))
      else $error("fast switch out of range");

   // analog channels carry a zero lsb
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !rsp_ch.chan_0[0] && !rsp_ch.chan_1[0] &&
                       !rsp_ch.chan_2[0] && !rsp_ch.chan_3[0])
      else $error("analog lsb set");

endmodule

bind rc_hybrid_switch_unpacker rchsu_checker u_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
